### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the priority schedule block
// Sizes, store entry layout, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Batch and field sizes
    localparam int MAX_JOBS = 16;
    localparam int BURST_W  = 16;
    localparam int PRI_W    = 8;
    localparam int NUM_W    = 4;
    localparam int JOB_W    = 5;
    localparam int WAIT_W   = 20;
    localparam int TOT_W    = 24;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // One stored job
    typedef struct packed {
        logic [PRI_W-1:0]   prio;
        logic [BURST_W-1:0] burst;
        logic [NUM_W-1:0]   num;
    } pst_entry_t;

    // Controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_INIT,
        S_SORT_SCAN,
        S_SORT_SWAP,
        S_EMIT_READ,
        S_DIV_START,
        S_DIV_WAIT,
        S_SHOW
    } pst_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_job;
        logic row_start;
        logic scan_step;
        logic swap;
        logic emit_start;
        logic emit_load;
        logic div_start;
        logic take_avg;
        logic batch_clear;
    } pst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full_next;
        logic row_done;
        logic scan_done;
        logic emit_last;
        logic final_item;
        logic div_busy;
    } pst_status_t;

endpackage

### rtl/priority_schedule_timing.sv
// ----------------------------------------------------------------------------
// priority_schedule_timing: non-preemptive priority scheduler for one batch
// Loads up to MAX_JOBS jobs, orders them by ascending priority and emits
// one timing result per job in served order.
// ----------------------------------------------------------------------------
// Jobs are taken one per cycle while the block is loading. The job marked
// last, or the one that fills the sixteen-entry store, closes the batch and
// the input side stays closed until the final result is taken. The selection
// sort visits one store entry per cycle: each row scans the remaining
// entries and ends with a swap of the row minimum into place. Each result is
// then read from the store into the output registers and held until m_ready,
// and the final result first waits for the two 24-step restoring dividers
// that form the averages.
// ----------------------------------------------------------------------------
module priority_schedule_timing
    import pst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BURST_W-1:0] s_burst_time,
    input  logic [PRI_W-1:0]   s_priority_req,
    input  logic               s_is_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [JOB_W-1:0]   m_job_number,
    output logic [BURST_W-1:0] m_burst_out,
    output logic [WAIT_W-1:0]  m_wait_time,
    output logic [WAIT_W-1:0]  m_turnaround_time,
    output logic [WAIT_W-1:0]  m_average_wait,
    output logic [WAIT_W-1:0]  m_average_turnaround,
    output logic               m_final_result
);

    pst_cmd_t    cmd;
    pst_status_t status;

    // Sequence the phases
    pst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Store, sort and compute results
    pst_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_burst           (s_burst_time),
        .in_prio            (s_priority_req),
        .job_number         (m_job_number),
        .burst_out          (m_burst_out),
        .wait_time          (m_wait_time),
        .turnaround_time    (m_turnaround_time),
        .average_wait       (m_average_wait),
        .average_turnaround (m_average_turnaround),
        .final_result       (m_final_result)
    );

endmodule

### rtl/pst_div.sv
// ----------------------------------------------------------------------------
// pst_div: restoring divider for the batch averages
// Divides a total by the job count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pst_div
    import pst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [TOT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output logic [TOT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(TOT_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [TOT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[TOT_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, div_reg}) : CNT_W'(trial);
            quo_next  = {quo_reg[TOT_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TOT_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

endmodule

### rtl/pst_datapath.sv
// ----------------------------------------------------------------------------
// pst_datapath: job store, selection sort and result datapath
// Holds the batch, performs the sort row by row, forms each result item and
// runs the average dividers.
// ----------------------------------------------------------------------------
module pst_datapath
    import pst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  pst_cmd_t           cmd,
    output pst_status_t        status,
    input  logic [BURST_W-1:0] in_burst,
    input  logic [PRI_W-1:0]   in_prio,
    output logic [JOB_W-1:0]   job_number,
    output logic [BURST_W-1:0] burst_out,
    output logic [WAIT_W-1:0]  wait_time,
    output logic [WAIT_W-1:0]  turnaround_time,
    output logic [WAIT_W-1:0]  average_wait,
    output logic [WAIT_W-1:0]  average_turnaround,
    output logic               final_result
);

    pst_entry_t         store_reg [MAX_JOBS];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [IDX_W-1:0]   pos_reg;
    pst_entry_t         save_reg;
    pst_entry_t         min_reg;
    logic [WAIT_W-1:0]  running_reg;
    logic [TOT_W-1:0]   wait_tot_reg;
    logic [TOT_W-1:0]   turn_tot_reg;
    logic [JOB_W-1:0]   job_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic [WAIT_W-1:0]  turn_reg;
    logic [WAIT_W-1:0]  avg_wait_reg;
    logic [WAIT_W-1:0]  avg_turn_reg;
    logic               final_reg;

    logic [IDX_W-1:0]   rd_addr;
    pst_entry_t         rd_entry;
    logic [WAIT_W-1:0]  burst_ext;
    logic [WAIT_W-1:0]  turn_now;
    logic               div_w_busy, div_t_busy;
    logic [TOT_W-1:0]   quo_w, quo_t;

    // Select the single read address of the store
    always_comb begin
        if (cmd.row_start) begin
            rd_addr = i_reg[IDX_W-1:0];
        end else if (cmd.emit_load) begin
            rd_addr = k_reg[IDX_W-1:0];
        end else begin
            rd_addr = j_reg[IDX_W-1:0];
        end
    end

    assign rd_entry  = store_reg[rd_addr];
    assign burst_ext = {{(WAIT_W-BURST_W){1'b0}}, rd_entry.burst};
    assign turn_now  = running_reg + burst_ext;

    // Write the store: load a job or swap the row minimum into place
    always_ff @(posedge aclk) begin
        if (cmd.load_job) begin
            store_reg[count_reg[IDX_W-1:0]] <= '{prio: in_prio, burst: in_burst,
                                                 num: count_reg[NUM_W-1:0]};
        end else if (cmd.swap) begin
            if (pos_reg != i_reg[IDX_W-1:0]) begin
                store_reg[pos_reg] <= save_reg;
            end
            store_reg[i_reg[IDX_W-1:0]]   <= min_reg;
        end
    end

    // Advance counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            final_reg <= 1'b0;
        end else begin
            if (cmd.load_job) begin
                count_reg <= count_reg + 1'b1;
                i_reg     <= '0;
            end else if (cmd.batch_clear) begin
                count_reg <= '0;
            end
            if (cmd.row_start) begin
                j_reg <= i_reg + 1'b1;
            end else if (cmd.scan_step) begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.swap) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.emit_start) begin
                k_reg <= '0;
            end else if (cmd.emit_load) begin
                k_reg     <= k_reg + 1'b1;
                final_reg <= status.emit_last;
            end
        end
    end

    // Track the row minimum, first one wins on ties
    always_ff @(posedge aclk) begin
        if (cmd.row_start) begin
            save_reg <= rd_entry;
            min_reg  <= rd_entry;
            pos_reg  <= i_reg[IDX_W-1:0];
        end else if (cmd.scan_step && (rd_entry.prio < min_reg.prio)) begin
            min_reg <= rd_entry;
            pos_reg <= j_reg[IDX_W-1:0];
        end
    end

    // Form result items and accumulate totals
    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            running_reg  <= '0;
            wait_tot_reg <= '0;
            turn_tot_reg <= '0;
        end else if (cmd.emit_load) begin
            job_reg      <= {{(JOB_W-NUM_W){1'b0}}, rd_entry.num} + 1'b1;
            burst_reg    <= rd_entry.burst;
            wait_reg     <= running_reg;
            turn_reg     <= turn_now;
            avg_wait_reg <= '0;
            avg_turn_reg <= '0;
            running_reg  <= turn_now;
            wait_tot_reg <= wait_tot_reg + {{(TOT_W-WAIT_W){1'b0}}, running_reg};
            turn_tot_reg <= turn_tot_reg + {{(TOT_W-WAIT_W){1'b0}}, turn_now};
        end else if (cmd.take_avg) begin
            avg_wait_reg <= quo_w[WAIT_W-1:0];
            avg_turn_reg <= quo_t[WAIT_W-1:0];
        end
    end

    // Average dividers
    pst_div u_div_wait (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (wait_tot_reg),
        .divisor  (count_reg),
        .busy     (div_w_busy),
        .quotient (quo_w)
    );

    pst_div u_div_turn (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (turn_tot_reg),
        .divisor  (count_reg),
        .busy     (div_t_busy),
        .quotient (quo_t)
    );

    // Report status
    always_comb begin
        status.full_next  = (count_reg == CNT_W'(MAX_JOBS - 1));
        status.row_done   = ((i_reg + 1'b1) >= count_reg);
        status.scan_done  = (j_reg == count_reg);
        status.emit_last  = ((k_reg + 1'b1) == count_reg);
        status.final_item = final_reg;
        status.div_busy   = div_w_busy | div_t_busy;
    end

    assign job_number         = job_reg;
    assign burst_out          = burst_reg;
    assign wait_time          = wait_reg;
    assign turnaround_time    = turn_reg;
    assign average_wait       = avg_wait_reg;
    assign average_turnaround = avg_turn_reg;
    assign final_result       = final_reg;

endmodule

### rtl/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl: sequencer for load, sort, emit and average phases
// Drives datapath commands and the channel handshakes.
// ----------------------------------------------------------------------------
module pst_ctrl
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_is_last,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  pst_status_t status,
    output pst_cmd_t    cmd
);

    pst_state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid && (s_is_last || status.full_next)) begin
                    state_next = S_SORT_INIT;
                end
            end
            S_SORT_INIT: begin
                state_next = status.row_done ? S_EMIT_READ : S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                if (status.scan_done) begin
                    state_next = S_SORT_SWAP;
                end
            end
            S_SORT_SWAP: begin
                state_next = S_SORT_INIT;
            end
            S_EMIT_READ: begin
                state_next = status.emit_last ? S_DIV_START : S_SHOW;
            end
            S_DIV_START: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = S_SHOW;
                end
            end
            S_SHOW: begin
                if (m_ready) begin
                    state_next = status.final_item ? S_LOAD : S_EMIT_READ;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_ready      = 1'b1;
                cmd.load_job = s_valid;
            end
            S_SORT_INIT: begin
                cmd.emit_start = status.row_done;
                cmd.row_start  = !status.row_done;
            end
            S_SORT_SCAN: begin
                cmd.scan_step = !status.scan_done;
            end
            S_SORT_SWAP: begin
                cmd.swap = 1'b1;
            end
            S_EMIT_READ: begin
                cmd.emit_load = 1'b1;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                cmd.take_avg = !status.div_busy;
            end
            S_SHOW: begin
                m_valid         = 1'b1;
                cmd.batch_clear = m_ready && status.final_item;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides open together");

    a_last_sorts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_last) |=> (state_reg == S_SORT_INIT))
        else $error("last job did not start the sort");

    a_next_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !status.final_item) |=> (state_reg == S_EMIT_READ))
        else $error("batch emission did not continue");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the priority schedule block
// Feeds batches of jobs over the valid/ready input channel and predicts
// the served order, waiting and turnaround times and the averages of each
// batch. Every result item is compared field by field, in order; in the
// random tests both channels may idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import pst_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 170;

    // One expected result item
    typedef struct packed {
        logic [JOB_W-1:0]   job_number;
        logic [BURST_W-1:0] burst_out;
        logic [WAIT_W-1:0]  wait_time;
        logic [WAIT_W-1:0]  turnaround_time;
        logic [WAIT_W-1:0]  average_wait;
        logic [WAIT_W-1:0]  average_turnaround;
        logic               final_result;
    } served_job_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [BURST_W-1:0] s_burst_time    = '0;
    logic [PRI_W-1:0]   s_priority_req  = '0;
    logic               s_is_last       = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [JOB_W-1:0]   m_job_number;
    logic [BURST_W-1:0] m_burst_out;
    logic [WAIT_W-1:0]  m_wait_time;
    logic [WAIT_W-1:0]  m_turnaround_time;
    logic [WAIT_W-1:0]  m_average_wait;
    logic [WAIT_W-1:0]  m_average_turnaround;
    logic               m_final_result;

    // Predictor state: jobs of the batch being loaded
    logic [PRI_W-1:0]   batch_prio  [MAX_JOBS];
    logic [BURST_W-1:0] batch_burst [MAX_JOBS];
    logic [NUM_W-1:0]   batch_num   [MAX_JOBS];
    int                 batch_count = 0;
    served_job_t        served_jobs_q[$];

    int   error_count     = 0;
    int   cycle_count     = 0;
    bit   sender_idles    = 1'b0;
    bit   receiver_stalls = 1'b0;
    bit   hold_request    = 1'b0;
    int   hold_left       = 0;
    int   ready_gap       = 0;

    priority_schedule_timing i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_burst_time         (s_burst_time),
        .s_priority_req       (s_priority_req),
        .s_is_last            (s_is_last),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_job_number         (m_job_number),
        .m_burst_out          (m_burst_out),
        .m_wait_time          (m_wait_time),
        .m_turnaround_time    (m_turnaround_time),
        .m_average_wait       (m_average_wait),
        .m_average_turnaround (m_average_turnaround),
        .m_final_result       (m_final_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Store one job; on the closing job, order the batch and queue its results
    task automatic schedule_job(input logic [BURST_W-1:0] burst,
                                input logic [PRI_W-1:0] prio, input logic last);
        int                 n;
        int                 pos;
        logic [PRI_W-1:0]   t_prio;
        logic [BURST_W-1:0] t_burst;
        logic [NUM_W-1:0]   t_num;
        logic [WAIT_W-1:0]  run_wait;
        logic [WAIT_W-1:0]  wt;
        logic [WAIT_W-1:0]  tt;
        logic [TOT_W-1:0]   wait_sum;
        logic [TOT_W-1:0]   tat_sum;
        served_job_t        res;
        if (batch_count >= MAX_JOBS)
            batch_count = 0;
        batch_prio[batch_count]  = prio;
        batch_burst[batch_count] = burst;
        batch_num[batch_count]   = NUM_W'(batch_count);
        batch_count++;
        if (!last && batch_count < MAX_JOBS)
            return;
        n = batch_count;
        // Selection sort: first strict minimum, always swapped into place
        for (int i = 0; i < n; i++) begin
            pos = i;
            for (int j = i + 1; j < n; j++)
                if (batch_prio[j] < batch_prio[pos])
                    pos = j;
            t_prio  = batch_prio[i];
            t_burst = batch_burst[i];
            t_num   = batch_num[i];
            batch_prio[i]    = batch_prio[pos];
            batch_burst[i]   = batch_burst[pos];
            batch_num[i]     = batch_num[pos];
            batch_prio[pos]  = t_prio;
            batch_burst[pos] = t_burst;
            batch_num[pos]   = t_num;
        end
        // Serve in order, accumulating waits and turnarounds
        run_wait = '0;
        wait_sum = '0;
        tat_sum  = '0;
        for (int k = 0; k < n; k++) begin
            wt       = run_wait;
            tt       = wt + WAIT_W'(batch_burst[k]);
            wait_sum = wait_sum + TOT_W'(wt);
            tat_sum  = tat_sum + TOT_W'(tt);
            res.job_number         = JOB_W'(batch_num[k]) + JOB_W'(1);
            res.burst_out          = batch_burst[k];
            res.wait_time          = wt;
            res.turnaround_time    = tt;
            res.average_wait       = '0;
            res.average_turnaround = '0;
            res.final_result       = (k == n - 1);
            if (k == n - 1) begin
                res.average_wait       = WAIT_W'(wait_sum / TOT_W'(n));
                res.average_turnaround = WAIT_W'(tat_sum / TOT_W'(n));
            end
            served_jobs_q.push_back(res);
            run_wait = run_wait + WAIT_W'(batch_burst[k]);
        end
        batch_count = 0;
    endtask

    // Predict on every accepted input item
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            schedule_job(s_burst_time, s_priority_req, s_is_last);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result item with the oldest prediction
    always @(posedge aclk) begin
        served_job_t want;
        if (aresetn && m_valid && m_ready) begin
            if (served_jobs_q.size() == 0) begin
                $error("unexpected result item: job_number %0d", m_job_number);
                error_count++;
            end else begin
                want = served_jobs_q.pop_front();
                check_field("job_number", 32'(want.job_number), 32'(m_job_number));
                check_field("burst_out", 32'(want.burst_out), 32'(m_burst_out));
                check_field("wait_time", 32'(want.wait_time), 32'(m_wait_time));
                check_field("turnaround_time", 32'(want.turnaround_time),
                            32'(m_turnaround_time));
                check_field("average_wait", 32'(want.average_wait),
                            32'(m_average_wait));
                check_field("average_turnaround", 32'(want.average_turnaround),
                            32'(m_average_turnaround));
                check_field("final_result", 32'(want.final_result),
                            32'(m_final_result));
            end
        end
    end

    // Drive m_ready: long hold-off on request, else random stalls when enabled
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (receiver_stalls)
                ready_gap = pick_gap();
        end
    end

    // Offer one item; entered and left at a falling edge, valid kept high
    task automatic send_job(input logic [BURST_W-1:0] burst,
                            input logic [PRI_W-1:0] prio, input logic last);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_burst_time   <= burst;
        s_priority_req <= prio;
        s_is_last      <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // One-job batches at both extremes
    task automatic test_single_job_batches();
        send_job('0, '0, 1'b1);
        send_job('1, '1, 1'b1);
    endtask

    // Equal priorities: the sort's swap order decides the served order
    task automatic test_equal_priority_ties();
        for (int i = 0; i < 4; i++)
            send_job(BURST_W'(i + 1), PRI_W'(7), i == 3);
    endtask

    // Sixteen jobs with no last mark: the full store closes the batch
    task automatic test_full_store();
        for (int i = 0; i < MAX_JOBS; i++)
            send_job('1, (i < 8) ? PRI_W'(255 - i) : PRI_W'(i & 1), 1'b0);
    endtask

    // Hold the result side off while the sender keeps offering full batches
    task automatic test_output_hold_off();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 1'b1;
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < MAX_JOBS; i++)
                send_job(BURST_W'($urandom), PRI_W'($urandom), i == MAX_JOBS - 1);
    endtask

    // Random batches of random size, some with heavy priority ties
    task automatic test_random_batches();
        int                 sent;
        int                 size;
        int                 prio_mode;
        logic [BURST_W-1:0] burst;
        logic [PRI_W-1:0]   prio;
        logic               last;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            size      = $urandom_range(MAX_JOBS, 1);
            prio_mode = $urandom_range(3);
            // Some batches run with no idling at all
            sender_idles    = ($urandom_range(3) != 0);
            receiver_stalls = ($urandom_range(3) != 0);
            for (int k = 0; k < size; k++) begin
                case ($urandom_range(9))
                    0: burst = '0;
                    1: burst = '1;
                    default: burst = BURST_W'($urandom);
                endcase
                if (prio_mode == 0)
                    prio = PRI_W'($urandom_range(3));
                else if (prio_mode == 1)
                    prio = ($urandom_range(1) != 0) ? '1 : '0;
                else
                    prio = PRI_W'($urandom);
                if (k != size - 1)
                    last = 1'b0;
                else if (size == MAX_JOBS)
                    last = 1'($urandom_range(1));
                else
                    last = 1'b1;
                send_job(burst, prio, last);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_job_batches();
        test_equal_priority_ties();
        test_full_store();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_random_batches();
        test_output_hold_off();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        test_random_batches();

        // Drain outstanding results, then let the block settle
        s_valid <= 1'b0;
        while (served_jobs_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/pst_pkg.sv
rtl/pst_div.sv
rtl/pst_datapath.sv
rtl/pst_ctrl.sv
rtl/priority_schedule_timing.sv
dv/tb_top.sv
